// ----- rtl/cpts_pkg.sv -----
// ============================================================================
// cpts_pkg: shared definitions for the counter priority task scheduler
// Slot table geometry, field widths, operation codes, table word layout and
// the opcodes of the shared arithmetic unit.
// ============================================================================
package cpts_pkg;

    // Slot table geometry
    localparam int NUM_SLOTS = 64;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int IDX_W     = $clog2(NUM_SLOTS + 1);

    // Beat field widths
    localparam int FUNC_W  = 3;
    localparam int TASK_W  = 6;
    localparam int PRIO_W  = 8;
    localparam int SCNT_W  = 9;
    localparam int CNT_W   = 16;
    localparam int DEPTH_W = 8;

    // Operation codes carried in func
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_YIELD   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_HOLD    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 3'd4;

    // Counter and depth limits
    localparam logic signed [CNT_W-1:0] CNT_MIN   = 16'sh8000;
    localparam logic signed [CNT_W-1:0] CNT_NONE  = -16'sd1;
    localparam logic signed [CNT_W-1:0] CNT_ONE   = 16'sd1;
    localparam logic [DEPTH_W-1:0]      DEPTH_MAX = 8'hFF;
    localparam logic [PRIO_W-1:0]       PRIO_RESET = 8'd1;

    // Shared arithmetic unit opcodes
    typedef logic [1:0] alu_op_t;
    localparam alu_op_t ALU_ADD      = 2'd0;
    localparam alu_op_t ALU_HALF_ADD = 2'd1;
    localparam alu_op_t ALU_CMP      = 2'd2;

    // One stored slot word
    typedef struct packed {
        logic [PRIO_W-1:0]         prio;
        logic signed [CNT_W-1:0]   cnt;
        logic [DEPTH_W-1:0]        depth;
    } slot_word_t;

    localparam slot_word_t RESET_WORD = '{prio: PRIO_RESET, cnt: '0, depth: '0};

    // Slot as seen on the table read port
    typedef struct packed {
        logic       valid;
        logic       runnable;
        slot_word_t word;
    } slot_entry_t;

    // Table write request
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        slot_word_t        word;
        logic              flags_en;
        logic              valid;
        logic              runnable;
    } table_wr_t;

endpackage

// ----- rtl/cpts_if.sv -----
// ============================================================================
// cpts_cmd_if / cpts_result_if: valid-ready channels of the scheduler
// Command beats carry one operation; result beats carry the current task.
// ============================================================================
interface cpts_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [cpts_pkg::FUNC_W-1:0]      func;
    logic [cpts_pkg::TASK_W-1:0]      slot;
    logic                             valid_req;
    logic                             runnable;
    logic [cpts_pkg::PRIO_W-1:0]      prio;
    logic [cpts_pkg::SCNT_W-1:0]      start_count;

    modport source (output valid, func, slot, valid_req, runnable, prio, start_count,
                    input ready);
    modport sink   (input valid, func, slot, valid_req, runnable, prio, start_count,
                    output ready);
endinterface

interface cpts_result_if;
    logic                             valid;
    logic                             ready;
    logic [cpts_pkg::TASK_W-1:0]      current_task;
    logic                             switched;
    logic                             refilled;
    logic signed [cpts_pkg::CNT_W-1:0] current_count;

    modport source (output valid, current_task, switched, refilled, current_count,
                    input ready);
    modport sink   (input valid, current_task, switched, refilled, current_count,
                    output ready);
endinterface

// ----- rtl/cpts_table.sv -----
// ============================================================================
// cpts_table: task slot table
// Priority, counter and depth live in a single-port-write, single-port-read
// memory with registered read. Valid, runnable and written flags are flops
// cleared by reset; a never-written slot reads back as the reset word.
// ============================================================================
module cpts_table (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [cpts_pkg::SLOT_W-1:0] rd_addr,
    output cpts_pkg::slot_entry_t     rd_entry,
    input  cpts_pkg::table_wr_t       wr
);
    import cpts_pkg::*;

    slot_word_t           slot_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [NUM_SLOTS-1:0] run_reg;
    logic [NUM_SLOTS-1:0] init_reg;

    slot_word_t rd_word_reg;
    logic       rd_valid_reg;
    logic       rd_run_reg;
    logic       rd_init_reg;

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            slot_mem[wr.addr] <= wr.word;
        end
        rd_word_reg <= slot_mem[rd_addr];
    end

    // Per-slot flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            run_reg      <= '0;
            init_reg     <= '0;
            rd_valid_reg <= 1'b0;
            rd_run_reg   <= 1'b0;
            rd_init_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                init_reg[wr.addr] <= 1'b1;
                if (wr.flags_en)
                begin
                    valid_reg[wr.addr] <= wr.valid;
                    run_reg[wr.addr]   <= wr.runnable;
                end
            end
            rd_valid_reg <= valid_reg[rd_addr];
            rd_run_reg   <= run_reg[rd_addr];
            rd_init_reg  <= init_reg[rd_addr];
        end
    end

    // Unwritten slots read as reset values
    always_comb
    begin
        rd_entry.valid    = rd_valid_reg;
        rd_entry.runnable = rd_run_reg;
        rd_entry.word     = rd_init_reg ? rd_word_reg : RESET_WORD;
    end

endmodule

// ----- rtl/cpts_alu.sv -----
// ============================================================================
// cpts_alu: shared arithmetic and compare unit
// One 16-bit adder serves decrement, depth steps and counter refill; one
// signed comparator serves the best-slot scan.
// ============================================================================
module cpts_alu (
    input  cpts_pkg::alu_op_t                op,
    input  logic signed [cpts_pkg::CNT_W-1:0] a,
    input  logic signed [cpts_pkg::CNT_W-1:0] b,
    output logic signed [cpts_pkg::CNT_W-1:0] res,
    output logic                             gt
);
    import cpts_pkg::*;

    logic signed [CNT_W-1:0] lhs;

    // Operand shaping: halve for refill, pass through otherwise
    always_comb
    begin
        case (op)
            ALU_HALF_ADD: lhs = a >>> 1;
            ALU_ADD:      lhs = a;
            ALU_CMP:      lhs = a;
            default:      lhs = a;
        endcase
    end

    assign res = lhs + b;
    assign gt  = (a > b);

endmodule

// ----- rtl/counter_priority_task_scheduler_core.sv -----
// ============================================================================
// counter_priority_task_scheduler_core: goodness-counter task scheduler
// Keeps a table of task slots and runs tick, yield, preemption and load
// operations, rescheduling by a sweep over the slot table.
// ============================================================================
// One command beat is taken at a time; the block drops ready until the result
// is in its output register, and takes the next command while that result is
// still waiting. Load, preempt hold/release, unused codes and a tick that does
// not run out go through execute, a final read and the output register; a
// reschedule sweeps the slot table through its single read port, one slot a
// cycle, and a counter refill pass and a second scan are added when needed.
// Slot flags are cleared by reset directly; there is no clearing pass, and
// commands are taken right after reset.
module counter_priority_task_scheduler_core (
    input  logic          clk,
    input  logic          rst_n,
    cpts_cmd_if.sink      cmd,
    cpts_result_if.source result
);
    import cpts_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_REFILL = 3'd3;
    localparam logic [2:0] S_FIN_RD = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0] state_reg, state_next;

    // Captured command
    logic [FUNC_W-1:0] func_reg;
    logic [TASK_W-1:0] slot_reg;
    logic              valid_req_reg;
    logic              runnable_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [SCNT_W-1:0] start_count_reg;

    // Scheduler state
    logic [SLOT_W-1:0]       cur_reg, cur_next;
    logic                    sw_reg, sw_next;
    logic                    rf_reg, rf_next;
    logic signed [CNT_W-1:0] best_reg, best_next;
    logic [SLOT_W-1:0]       pick_reg, pick_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    dv_reg, dv_next;
    logic [SLOT_W-1:0]       didx_reg, didx_next;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    logic [TASK_W-1:0]       out_task_reg;
    logic                    out_sw_reg;
    logic                    out_rf_reg;
    logic signed [CNT_W-1:0] out_count_reg;

    logic                    cmd_take;
    logic                    fin_load;
    logic                    load_hit;
    logic                    resched;
    logic                    sweep_issue;
    logic                    sweep_done;
    logic signed [CNT_W-1:0] new_cnt;
    logic [DEPTH_W-1:0]      new_depth;

    logic [SLOT_W-1:0] rd_addr;
    slot_entry_t       rd_entry;
    table_wr_t         wr;

    alu_op_t                 alu_op;
    logic signed [CNT_W-1:0] alu_a;
    logic signed [CNT_W-1:0] alu_b;
    logic signed [CNT_W-1:0] alu_res;
    logic                    alu_gt;

    cpts_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .wr       (wr)
    );

    cpts_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .gt  (alu_gt)
    );

    assign cmd.ready   = (state_reg == S_IDLE);
    assign cmd_take    = cmd.valid && cmd.ready;
    assign fin_load    = (state_reg == S_FIN) && (!out_valid_reg || result.ready);
    assign load_hit    = (32'(slot_reg) < 32'(NUM_SLOTS));
    assign sweep_issue = (idx_reg < IDX_W'(NUM_SLOTS));
    assign sweep_done  = !sweep_issue && !dv_reg;

    // Sequencer and datapath control
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        sw_next    = sw_reg;
        rf_next    = rf_reg;
        best_next  = best_reg;
        pick_next  = pick_reg;
        idx_next   = idx_reg;
        dv_next    = dv_reg;
        didx_next  = didx_reg;
        rd_addr    = cur_reg;
        wr         = '0;
        alu_op     = ALU_CMP;
        alu_a      = rd_entry.word.cnt;
        alu_b      = best_reg;
        resched    = 1'b0;
        new_cnt    = rd_entry.word.cnt;
        new_depth  = rd_entry.word.depth;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    sw_next    = 1'b0;
                    rf_next    = 1'b0;
                    state_next = S_EXEC;
                end
            end

            // Read-modify-write of the current slot, or a slot load
            S_EXEC:
            begin
                wr.addr = cur_reg;
                wr.word = rd_entry.word;
                case (func_reg)
                    FUNC_TICK:
                    begin
                        alu_op = ALU_ADD;
                        alu_b  = CNT_NONE;
                        if (rd_entry.word.cnt != CNT_MIN)
                        begin
                            new_cnt = alu_res;
                        end
                        resched = !((!new_cnt[CNT_W-1] && (new_cnt != '0))
                                    || (rd_entry.word.depth != '0));
                        wr.en       = 1'b1;
                        wr.word.cnt = resched ? '0 : new_cnt;
                    end
                    FUNC_YIELD:
                    begin
                        resched     = 1'b1;
                        wr.en       = 1'b1;
                        wr.word.cnt = '0;
                    end
                    FUNC_HOLD:
                    begin
                        alu_op = ALU_ADD;
                        alu_a  = $signed(CNT_W'(rd_entry.word.depth));
                        alu_b  = CNT_ONE;
                        if (rd_entry.word.depth != DEPTH_MAX)
                        begin
                            new_depth = alu_res[DEPTH_W-1:0];
                        end
                        wr.en         = 1'b1;
                        wr.word.depth = new_depth;
                    end
                    FUNC_RELEASE:
                    begin
                        alu_op = ALU_ADD;
                        alu_a  = $signed(CNT_W'(rd_entry.word.depth));
                        alu_b  = CNT_NONE;
                        if (rd_entry.word.depth != '0)
                        begin
                            new_depth = alu_res[DEPTH_W-1:0];
                        end
                        wr.en         = 1'b1;
                        wr.word.depth = new_depth;
                    end
                    FUNC_LOAD:
                    begin
                        wr.en         = load_hit;
                        wr.addr       = SLOT_W'(slot_reg);
                        wr.word.prio  = prio_reg;
                        wr.word.cnt   = $signed(CNT_W'(start_count_reg));
                        wr.word.depth = '0;
                        wr.flags_en   = 1'b1;
                        wr.valid      = valid_req_reg;
                        wr.runnable   = runnable_reg;
                    end
                    default:
                    begin
                        wr.en = 1'b0;
                    end
                endcase

                if (resched)
                begin
                    best_next  = CNT_NONE;
                    pick_next  = '0;
                    idx_next   = '0;
                    dv_next    = 1'b0;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_FIN_RD;
                end
            end

            // Best-slot scan, one slot a cycle
            S_SCAN:
            begin
                dv_next = sweep_issue;
                if (sweep_issue)
                begin
                    rd_addr   = idx_reg[SLOT_W-1:0];
                    idx_next  = idx_reg + 1'b1;
                    didx_next = idx_reg[SLOT_W-1:0];
                end
                if (dv_reg && rd_entry.valid && rd_entry.runnable && alu_gt)
                begin
                    best_next = rd_entry.word.cnt;
                    pick_next = didx_reg;
                end
                if (sweep_done)
                begin
                    if ((best_reg == '0) && !rf_reg)
                    begin
                        rf_next    = 1'b1;
                        idx_next   = '0;
                        state_next = S_REFILL;
                    end
                    else
                    begin
                        sw_next    = (pick_reg != cur_reg);
                        cur_next   = pick_reg;
                        state_next = S_FIN_RD;
                    end
                end
            end

            // Counter refill of every valid slot
            S_REFILL:
            begin
                dv_next = sweep_issue;
                if (sweep_issue)
                begin
                    rd_addr   = idx_reg[SLOT_W-1:0];
                    idx_next  = idx_reg + 1'b1;
                    didx_next = idx_reg[SLOT_W-1:0];
                end
                alu_op = ALU_HALF_ADD;
                alu_b  = $signed(CNT_W'(rd_entry.word.prio));
                if (dv_reg && rd_entry.valid)
                begin
                    wr.en       = 1'b1;
                    wr.addr     = didx_reg;
                    wr.word     = rd_entry.word;
                    wr.word.cnt = alu_res;
                end
                if (sweep_done)
                begin
                    best_next  = CNT_NONE;
                    pick_next  = '0;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end

            S_FIN_RD:
            begin
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (fin_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fin_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            sw_reg        <= 1'b0;
            rf_reg        <= 1'b0;
            best_reg      <= CNT_NONE;
            pick_reg      <= '0;
            idx_reg       <= '0;
            dv_reg        <= 1'b0;
            didx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            sw_reg        <= sw_next;
            rf_reg        <= rf_next;
            best_reg      <= best_next;
            pick_reg      <= pick_next;
            idx_reg       <= idx_next;
            dv_reg        <= dv_next;
            didx_reg      <= didx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            func_reg        <= cmd.func;
            slot_reg        <= cmd.slot;
            valid_req_reg   <= cmd.valid_req;
            runnable_reg    <= cmd.runnable;
            prio_reg        <= cmd.prio;
            start_count_reg <= cmd.start_count;
        end
        if (fin_load)
        begin
            out_task_reg  <= TASK_W'(cur_reg);
            out_sw_reg    <= sw_reg;
            out_rf_reg    <= rf_reg;
            out_count_reg <= rd_entry.word.cnt;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.current_task  = out_task_reg;
    assign result.switched      = out_sw_reg;
    assign result.refilled      = out_rf_reg;
    assign result.current_count = out_count_reg;

`ifndef SYNTH
    // One command at a time: ready drops right after a command beat
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> !cmd.ready)
    else $error("command accepted while a previous one is in flight");

    // Only tick and yield can trigger a counter refill
    assert property (@(posedge clk) disable iff (!rst_n)
        (fin_load && rf_reg) |-> (func_reg == FUNC_TICK || func_reg == FUNC_YIELD))
    else $error("refill reported for an operation that does not reschedule");

    // Sweep index never runs past the table
    assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_W'(NUM_SLOTS))
    else $error("slot sweep index out of range");
`endif

endmodule
